[src/pcrn_pkg.sv]
// Shared constants, types and tap table for the C/A code replica with code NCO.
`timescale 1ns / 1ps

package pcrn_pkg;

    localparam int CODE_LENGTH = 1023;
    localparam int HALF_CHIPS  = 2 * CODE_LENGTH;
    localparam int ADDR_W      = $clog2(CODE_LENGTH);
    localparam int IDX_W       = $clog2(HALF_CHIPS);
    localparam int PHASE_BITS  = 32;
    localparam int PRN_W       = 6;
    localparam int SEL_W       = 5;
    localparam int LFSR_W      = 10;

    localparam logic [LFSR_W-1:0] LFSR_SEED = '1;
    localparam logic [SEL_W-1:0]  SEL_PRN1  = '0;

    localparam logic CFG_IDX_PRN  = 1'b0;
    localparam logic CFG_IDX_STEP = 1'b1;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic              data;
    } t_ram_wr;

    function automatic logic [LFSR_W-1:0] g2_tap_mask(input logic [SEL_W-1:0] sel);
        logic [LFSR_W-1:0] m;
        case (sel)
            5'd0:    m = 10'b0000100010;
            5'd1:    m = 10'b0001000100;
            5'd2:    m = 10'b0010001000;
            5'd3:    m = 10'b0100010000;
            5'd4:    m = 10'b0100000001;
            5'd5:    m = 10'b1000000010;
            5'd6:    m = 10'b0010000001;
            5'd7:    m = 10'b0100000010;
            5'd8:    m = 10'b1000000100;
            5'd9:    m = 10'b0000000110;
            5'd10:   m = 10'b0000001100;
            5'd11:   m = 10'b0000110000;
            5'd12:   m = 10'b0001100000;
            5'd13:   m = 10'b0011000000;
            5'd14:   m = 10'b0110000000;
            5'd15:   m = 10'b1100000000;
            5'd16:   m = 10'b0000001001;
            5'd17:   m = 10'b0000010010;
            5'd18:   m = 10'b0000100100;
            5'd19:   m = 10'b0001001000;
            5'd20:   m = 10'b0010010000;
            5'd21:   m = 10'b0100100000;
            5'd22:   m = 10'b0000000101;
            5'd23:   m = 10'b0000101000;
            5'd24:   m = 10'b0001010000;
            5'd25:   m = 10'b0010100000;
            5'd26:   m = 10'b0101000000;
            5'd27:   m = 10'b1010000000;
            5'd28:   m = 10'b0000100001;
            5'd29:   m = 10'b0001000010;
            5'd30:   m = 10'b0010000100;
            5'd31:   m = 10'b0100001000;
            default: m = 10'b0000100010;
        endcase
        return m;
    endfunction

endpackage

[src/prn_code_replica_nco.sv]
// Top level: C/A code replica with code NCO, table RAM and output pipeline.
//
//  channel   direction  handshake              payload
//  s_axis    in         i_s_tvalid/o_s_tready  tdata[10:0] offset
//  m_axis    out        o_m_tvalid/i_m_tready  tdata[0] chip, tuser[0] epoch
//  cfg       in         i_cfg_valid/o_cfg_ready index 0 prn, index 1 code_step
//
// One sample per cycle while the table is not being filled and the output is not stalled;
// each result passes through the table RAM read register, then the output register.
// After reset and after every prn write the generator fills the 1023-entry
// code table, one chip a cycle; no sample is taken while it is busy.
// A stalled output holds the pipeline; the input stalls while the table is
// being filled, or when both stages are full and the output is stalled.
`timescale 1ns / 1ps

module prn_code_replica_nco
    import pcrn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // [10:0] offset, [15:11] zero
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [0] chip, [7:1] zero
    output logic [0:0]  o_m_tuser,   // [0] epoch
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_ram_wr           w_wr;
    logic              w_busy;
    logic              w_prn_we;
    logic              w_step_we;
    logic              w_accept;
    logic              w_out_free;
    logic              w_s1_move;
    logic [ADDR_W-1:0] w_raddr;
    logic              w_epoch;
    logic              w_rdata;

    logic r_s1_valid;
    logic r_s1_epoch;
    logic r_out_valid;
    logic r_out_chip;
    logic r_out_epoch;

    assign o_cfg_ready = 1'b1;
    assign w_prn_we    = i_cfg_valid && (i_cfg_index[0] == CFG_IDX_PRN);
    assign w_step_we   = i_cfg_valid && (i_cfg_index[0] == CFG_IDX_STEP);

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_s1_move  = r_s1_valid && w_out_free;
    assign o_s_tready = !w_busy && (!r_s1_valid || w_out_free);
    assign w_accept   = i_s_tvalid && o_s_tready;

    pcrn_gen u_gen (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_prn_we),
        .i_prn   (i_cfg_data[PRN_W-1:0]),
        .o_wr    (w_wr),
        .o_busy  (w_busy)
    );

    pcrn_nco u_nco (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (w_prn_we),
        .i_step_we (w_step_we),
        .i_step    (i_cfg_data[PHASE_BITS-1:0]),
        .i_advance (w_accept),
        .i_offset  (i_s_tdata[IDX_W-1:0]),
        .o_addr    (w_raddr),
        .o_epoch   (w_epoch)
    );

    pcrn_ram #(
        .WIDTH (1),
        .DEPTH (CODE_LENGTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_wr.we),
        .i_waddr (w_wr.addr),
        .i_wdata (w_wr.data),
        .i_re    (w_accept),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (w_s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (w_s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_epoch <= w_epoch;
        end
        if (w_s1_move) begin
            r_out_chip  <= w_rdata;
            r_out_epoch <= r_s1_epoch;
        end
    end

    assign o_m_tvalid   = r_out_valid;
    assign o_m_tdata    = {7'b0, r_out_chip};
    assign o_m_tuser[0] = r_out_epoch;

endmodule

[src/pcrn_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pcrn_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[src/pcrn_gen.sv]
// Gold code generator: sweeps G1/G2 once per period and fills the code table.
`timescale 1ns / 1ps

module pcrn_gen
    import pcrn_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [PRN_W-1:0] i_prn,
    output t_ram_wr          o_wr,
    output logic             o_busy
);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CODE_LENGTH - 1);

    logic              r_busy, n_busy;
    logic [ADDR_W-1:0] r_cnt, n_cnt;
    logic [LFSR_W-1:0] r_g1, n_g1;
    logic [LFSR_W-1:0] r_g2, n_g2;
    logic [SEL_W-1:0]  r_sel, n_sel;
    logic [LFSR_W-1:0] w_mask;
    logic              w_chip;

    assign w_mask = g2_tap_mask(r_sel);
    assign w_chip = r_g1[LFSR_W-1] ^ (^(r_g2 & w_mask));

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_g1   = r_g1;
        n_g2   = r_g2;
        n_sel  = r_sel;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_g1   = LFSR_SEED;
            n_g2   = LFSR_SEED;
            n_sel  = i_prn[SEL_W-1:0] - SEL_W'(1);
        end else if (r_busy) begin
            n_g1  = {r_g1[LFSR_W-2:0], r_g1[9] ^ r_g1[2]};
            n_g2  = {r_g2[LFSR_W-2:0],
                     r_g2[1] ^ r_g2[2] ^ r_g2[5] ^ r_g2[7] ^ r_g2[8] ^ r_g2[9]};
            n_cnt = r_cnt + ADDR_W'(1);
            if (r_cnt == LAST_ADDR) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_g1   <= LFSR_SEED;
            r_g2   <= LFSR_SEED;
            r_sel  <= SEL_PRN1;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
            r_g1   <= n_g1;
            r_g2   <= n_g2;
            r_sel  <= n_sel;
        end
    end

    assign o_wr.we   = r_busy && !i_start;
    assign o_wr.addr = r_cnt;
    assign o_wr.data = w_chip;
    assign o_busy    = r_busy;

endmodule

[src/pcrn_nco.sv]
// Code NCO: phase accumulator, half-chip index and code table read address.
`timescale 1ns / 1ps

module pcrn_nco
    import pcrn_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_clear,
    input  logic                  i_step_we,
    input  logic [PHASE_BITS-1:0] i_step,
    input  logic                  i_advance,
    input  logic [IDX_W-1:0]      i_offset,
    output logic [ADDR_W-1:0]     o_addr,
    output logic                  o_epoch
);

    localparam logic [IDX_W:0]   HALF_CHIPS_X  = (IDX_W+1)'(HALF_CHIPS);
    localparam logic [IDX_W:0]   HALF_CHIPS_X2 = (IDX_W+1)'(2 * HALF_CHIPS);
    localparam logic [IDX_W-1:0] LAST_IDX      = IDX_W'(HALF_CHIPS - 1);
    localparam logic [PHASE_BITS-1:0] STEP_RST = PHASE_BITS'(64'd1 << (PHASE_BITS - 1));

    logic [PHASE_BITS-1:0] r_step;
    logic [PHASE_BITS-1:0] r_frac, n_frac;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic [PHASE_BITS:0]   w_sum;
    logic [IDX_W:0]        w_pos_raw;
    logic [IDX_W:0]        w_pos;
    logic                  w_epoch;

    assign w_pos_raw = {1'b0, r_idx} + {1'b0, i_offset};
    assign w_pos     = (w_pos_raw >= HALF_CHIPS_X2) ? (w_pos_raw - HALF_CHIPS_X2) :
                       (w_pos_raw >= HALF_CHIPS_X)  ? (w_pos_raw - HALF_CHIPS_X)  :
                       w_pos_raw;
    assign o_addr    = w_pos[ADDR_W:1];

    assign w_sum = {1'b0, r_frac} + {1'b0, r_step};

    always_comb begin
        n_frac  = r_frac;
        n_idx   = r_idx;
        w_epoch = 1'b0;
        if (i_clear) begin
            n_frac = '0;
            n_idx  = '0;
        end else if (i_advance) begin
            n_frac = w_sum[PHASE_BITS-1:0];
            if (w_sum[PHASE_BITS]) begin
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    w_epoch = 1'b1;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
        end
    end

    assign o_epoch = w_epoch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_RST;
            r_frac <= '0;
            r_idx  <= '0;
        end else begin
            if (i_step_we) begin
                r_step <= i_step;
            end
            r_frac <= n_frac;
            r_idx  <= n_idx;
        end
    end

endmodule

[verif/prn_code_replica_nco_check.sv]
// Checker for the C/A code replica: predicts chip and epoch per sample and compares them.
`timescale 1ns / 1ps

module prn_code_replica_nco_check
    import pcrn_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,
    input  logic [0:0]  i_m_tuser,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [0:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic chip;
        logic epoch;
    } t_chip_result;

    localparam logic [0:31][3:0] G2_TAP_A = {
        4'd2, 4'd3, 4'd4, 4'd5, 4'd1, 4'd2, 4'd1, 4'd2,
        4'd3, 4'd2, 4'd3, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9,
        4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd1, 4'd4,
        4'd5, 4'd6, 4'd7, 4'd8, 4'd1, 4'd2, 4'd3, 4'd4
    };
    localparam logic [0:31][3:0] G2_TAP_B = {
        4'd6, 4'd7, 4'd8, 4'd9, 4'd9, 4'd10, 4'd8, 4'd9,
        4'd10, 4'd3, 4'd4, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10,
        4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd3, 4'd6,
        4'd7, 4'd8, 4'd9, 4'd10, 4'd6, 4'd7, 4'd8, 4'd9
    };

    logic                  code_chips [CODE_LENGTH];
    logic [PRN_W-1:0]      sat_num;
    logic [PHASE_BITS-1:0] nco_step;
    logic [PHASE_BITS-1:0] nco_frac;
    logic [IDX_W-1:0]      half_idx;
    t_chip_result          expected_chips [$];
    int                    fails = 0;

    task automatic rebuild_code(input logic [PRN_W-1:0] sat);
        logic [SEL_W-1:0]  sel;
        logic [LFSR_W-1:0] g1;
        logic [LFSR_W-1:0] g2;
        int                ta;
        int                tb;
        sel = sat[SEL_W-1:0] + 5'd31;
        ta  = int'(G2_TAP_A[sel]) - 1;
        tb  = int'(G2_TAP_B[sel]) - 1;
        g1  = LFSR_SEED;
        g2  = LFSR_SEED;
        for (int k = 0; k < CODE_LENGTH; k++) begin
            code_chips[k] = g1[9] ^ g2[ta] ^ g2[tb];
            g1 = {g1[8:0], g1[9] ^ g1[2]};
            g2 = {g2[8:0], ^(g2 & 10'h3A6)};
        end
        half_idx = '0;
        nco_frac = '0;
    endtask

    always @(posedge i_clk) begin : track
        t_chip_result        want;
        t_chip_result        got;
        int                  pos;
        logic [PHASE_BITS:0] sum;
        if (!i_rst_n) begin
            sat_num  = 6'd1;
            nco_step = 32'h8000_0000;
            rebuild_code(sat_num);
            expected_chips.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_IDX_PRN) begin
                    sat_num = i_cfg_data[PRN_W-1:0];
                    rebuild_code(sat_num);
                end else if (i_cfg_index == CFG_IDX_STEP) begin
                    nco_step = i_cfg_data;
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                got.chip  = i_m_tdata[0];
                got.epoch = i_m_tuser[0];
                if (expected_chips.size() == 0) begin
                    fails++;
                    $display("%0t: result with nothing expected, actual chip %0d epoch %0d",
                             $time, got.chip, got.epoch);
                end else begin
                    want = expected_chips.pop_front();
                    if (got.chip !== want.chip) begin
                        fails++;
                        $display("%0t: chip mismatch, expected %0d actual %0d",
                                 $time, want.chip, got.chip);
                    end
                    if (got.epoch !== want.epoch) begin
                        fails++;
                        $display("%0t: epoch mismatch, expected %0d actual %0d",
                                 $time, want.epoch, got.epoch);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                pos        = (int'(half_idx) + int'(i_s_tdata[10:0])) % HALF_CHIPS;
                want.chip  = code_chips[pos / 2];
                want.epoch = 1'b0;
                sum        = {1'b0, nco_frac} + {1'b0, nco_step};
                nco_frac   = sum[PHASE_BITS-1:0];
                if (sum[PHASE_BITS]) begin
                    if (half_idx == IDX_W'(HALF_CHIPS - 1)) begin
                        half_idx   = '0;
                        want.epoch = 1'b1;
                    end else begin
                        half_idx = half_idx + IDX_W'(1);
                    end
                end
                expected_chips.push_back(want);
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_chips.size();
    end

endmodule

[verif/prn_code_replica_nco_test.sv]
// Testbench top for the C/A code replica: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

module prn_code_replica_nco_test;
    import pcrn_pkg::*;

    localparam logic [0:11][10:0] CORNER_OFFSETS = {
        11'd0, 11'd1, 11'd2045, 11'd2046, 11'd2047, 11'd1022,
        11'd1023, 11'd1024, 11'h555, 11'h2AA, 11'd2, 11'd3
    };

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [15:0] i_s_tdata   = '0;
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [7:0]  o_m_tdata;
    logic [0:0]  o_m_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [0:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data  = '0;

    int fail_count;
    int pending;
    int src_idle_pct = 21;
    int snk_idle_pct = 72;
    int rx_count     = 0;
    int rx_hold      = 0;

    prn_code_replica_nco dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    prn_code_replica_nco_check checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    // hold off the output for a long stretch now and then
    always @(posedge i_clk) begin
        if (o_m_tvalid && i_m_tready) begin
            rx_count++;
            if (rx_count % 1000 == 200)
                rx_hold = 300;
        end
        if (rx_hold > 0)
            rx_hold--;
        i_m_tready <= (rx_hold == 0) && ($urandom_range(99) >= snk_idle_pct);
    end

    task automatic send_sample(input logic [10:0] offset);
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {5'd0, offset};
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] index, input logic [31:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [5:0] sat, input logic [31:0] step, input int count,
                             input int src_pct, input int snk_pct);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        write_reg(CFG_IDX_PRN, {26'd0, sat});
        write_reg(CFG_IDX_STEP, step);
        for (int n = 0; n < count; n++)
            send_sample(11'($urandom_range(2047)));
        wait_drained();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int n = 0; n < 12; n++)
            send_sample(CORNER_OFFSETS[n]);
        wait_drained();

        // prn 0 selects the same taps as prn 32
        write_reg(CFG_IDX_PRN, 32'd0);
        write_reg(CFG_IDX_STEP, 32'hFFFF_FFFF);
        send_sample(11'd2046);
        send_sample(11'd2047);
        send_sample(11'd0);
        send_sample(11'd1);
        send_sample(11'd2045);
        wait_drained();

        // prn 33 wraps to prn 1, frozen NCO
        write_reg(CFG_IDX_PRN, 32'd33);
        write_reg(CFG_IDX_STEP, 32'd0);
        send_sample(11'd0);
        send_sample(11'd2047);
        send_sample(11'd2);
        send_sample(11'd3);
        wait_drained();

        run_phase(6'd32, $urandom, 120, 21, 72);
        run_phase(6'd63, 32'd1, 120, 21, 72);
        run_phase(6'($urandom_range(63)), $urandom, 120, 72, 21);
        run_phase(6'd1, 32'h8000_0000, 120, 72, 21);
        run_phase(6'($urandom_range(63)), $urandom, 120, 0, 0);
        // full step, no gaps on either side
        run_phase(6'($urandom_range(63)), 32'hFFFF_FFFF, 280, 0, 0);

        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

[files.f]
src/pcrn_pkg.sv
src/pcrn_ram.sv
src/pcrn_gen.sv
src/pcrn_nco.sv
src/prn_code_replica_nco.sv
verif/prn_code_replica_nco_check.sv
verif/prn_code_replica_nco_test.sv
